FILE: sv/b62_pkg.sv
// Shared types, constants and the character classifier for the base-62 decoder.
// No dependencies; every other file imports this package.
package b62_pkg;

  localparam int MAX_DIGITS_DEF = 20;
  // 62^20 < 2^120, so a 120-bit magnitude never wraps.
  localparam int ACC_W          = 120;
  localparam int QUEUE_DEPTH    = 2;
  localparam int DIGIT_W        = 6;
  localparam int IN_DATA_W      = 8;
  localparam int VAL_LOW_W      = 64;
  localparam int VAL_HIGH_W     = 57;
  localparam int STATUS_W       = 2;
  localparam int OUT_DATA_W     = 128;

  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_MINUS,
    KIND_BAD,
    KIND_END
  } b62_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIGIT = 2'd1,
    ST_RANGE     = 2'd2
  } b62_status_e;

  typedef struct packed {
    b62_kind_e            kind;
    logic [DIGIT_W-1:0]   digit;
  } b62_item_t;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] UP_BASE  = 8'd10;
  localparam logic [7:0] LO_BASE  = 8'd36;

  // Maps one character to its kind and, for digits, its value 0..61.
  function automatic b62_item_t classify(input logic [7:0] ch, input logic last);
    b62_item_t  res;
    logic [7:0] val;
    begin
      res.kind  = KIND_BAD;
      res.digit = '0;
      val       = '0;
      if (last) begin
        res.kind = KIND_END;
      end else if (ch >= CH_0 && ch <= CH_9) begin
        res.kind = KIND_DIGIT;
        val      = ch - CH_0;
      end else if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
        res.kind = KIND_DIGIT;
        val      = ch - CH_UP_A + UP_BASE;
      end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
        res.kind = KIND_DIGIT;
        val      = ch - CH_LO_A + LO_BASE;
      end else if (ch == CH_MINUS) begin
        res.kind = KIND_MINUS;
      end
      res.digit = val[DIGIT_W-1:0];
      return res;
    end
  endfunction

endpackage

FILE: sv/b62_front.sv
// Front end of the base-62 decoder: takes input items and classifies each one.
// Depends on b62_pkg for the item type and the classify function.
module b62_front import b62_pkg::*; (
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [IN_DATA_W-1:0]  s_data_i,
  input  logic                  s_last_i,
  output logic                  push_o,
  output b62_item_t             push_item_o,
  input  logic                  queue_full_i
);

  assign s_ready_o   = !queue_full_i;
  assign push_o      = s_valid_i && !queue_full_i;
  assign push_item_o = classify(s_data_i, s_last_i);

endmodule

FILE: sv/b62_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on b62_pkg for the item type and the queue depth.
module b62_queue import b62_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  b62_item_t  push_item_i,
  output logic       full_o,
  input  logic       pop_i,
  output b62_item_t  head_o,
  output logic       empty_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  b62_item_t         entries_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: sv/b62_back.sv
// Back end of the base-62 decoder: runs the value*62+digit accumulator, the
// digit count and flags, and holds the finished result in an output register.
// Depends on b62_pkg for types, widths and status codes.
module b62_back import b62_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  b62_item_t              item_i,
  output logic                   pop_o,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic [VAL_LOW_W-1:0]   value_low_o,
  output logic [VAL_HIGH_W-1:0]  value_high_o,
  output logic [STATUS_W-1:0]    status_o
);

  localparam int CntW = $clog2(MAX_DIGITS + 2);
  localparam int ResW = VAL_LOW_W + VAL_HIGH_W;

  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   neg_q, neg_d;
  logic                   bad_q, bad_d;
  logic                   out_valid_q, out_valid_d;
  logic [ResW-1:0]        result_q, result_d;
  b62_status_e            status_q, status_d;

  logic                   slot_free;
  logic [CntW-1:0]        count_inc;
  logic [ACC_W-1:0]       acc_mac;
  logic [ResW-1:0]        magnitude;

  assign slot_free = !out_valid_q || m_ready_i;
  assign pop_o     = item_valid_i && ((item_i.kind != KIND_END) || slot_free);

  assign count_inc = (count_q < CntW'(MAX_DIGITS + 1)) ? count_q + 1'b1 : count_q;
  // value*62 + digit, as value*64 - value*2 + digit.
  assign acc_mac   = (acc_q << 6) - (acc_q << 1) + ACC_W'(item_i.digit);
  assign magnitude = ResW'(acc_q);

  always_comb begin
    acc_d       = acc_q;
    count_d     = count_q;
    neg_d       = neg_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && !m_ready_i;
    result_d    = result_q;
    status_d    = status_q;
    if (pop_o) begin
      case (item_i.kind)
        KIND_END: begin
          out_valid_d = 1'b1;
          result_d    = '0;
          if ((count_q == '0 && !neg_q) || count_q > CntW'(MAX_DIGITS)) begin
            status_d = ST_RANGE;
          end else if (bad_q) begin
            status_d = ST_BAD_DIGIT;
          end else begin
            status_d = ST_OK;
            result_d = neg_q ? (~magnitude + 1'b1) : magnitude;
          end
          acc_d   = '0;
          count_d = '0;
          neg_d   = 1'b0;
          bad_d   = 1'b0;
        end
        default: begin
          // A minus counts as a sign only when it is the very first item.
          if (item_i.kind == KIND_MINUS && count_q == '0 && !neg_q) begin
            neg_d = 1'b1;
          end else begin
            count_d = count_inc;
            if (count_inc <= CntW'(MAX_DIGITS)) begin
              if (item_i.kind != KIND_DIGIT) begin
                bad_d = 1'b1;
              end else if (!bad_q) begin
                acc_d = acc_mac;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      count_q     <= '0;
      neg_q       <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      count_q     <= count_d;
      neg_q       <= neg_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    status_q <= status_d;
  end

  assign m_valid_o    = out_valid_q;
  assign value_low_o  = result_q[VAL_LOW_W-1:0];
  assign value_high_o = result_q[ResW-1:VAL_LOW_W];
  assign status_o     = status_q;

endmodule

FILE: sv/base62_text_to_int128.sv
// Streaming base-62 text to signed 121-bit integer decoder, one character per item.
// Throughput: one item per cycle unless an end item waits on a result not yet taken;
// the accumulator's multiply-by-62 and add is the loop.
// A two-entry queue parts the classifier from the accumulator; the result register
// parts the accumulator from the output. A result that is not taken holds back only
// the next end item, and input stalls once that item and one more fill the queue.
// Reset (rst_ni low, asynchronous) clears the accumulator, count, flags and queue.
module base62_text_to_int128 import b62_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // [7:0] char_code
  input  logic                   s_axis_tlast,   // end_mark
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata    // [63:0] value_low, [120:64] value_high,
                                                 // [122:121] status, rest zero
);

  localparam int PadW = OUT_DATA_W - VAL_LOW_W - VAL_HIGH_W - STATUS_W;

  logic                   push;
  b62_item_t              push_item;
  logic                   queue_full;
  logic                   pop;
  b62_item_t              head;
  logic                   queue_empty;
  logic [VAL_LOW_W-1:0]   value_low;
  logic [VAL_HIGH_W-1:0]  value_high;
  logic [STATUS_W-1:0]    status;

  b62_front u_front (
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_last_i     (s_axis_tlast),
    .push_o       (push),
    .push_item_o  (push_item),
    .queue_full_i (queue_full)
  );

  b62_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (queue_empty)
  );

  b62_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!queue_empty),
    .item_i       (head),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .value_low_o  (value_low),
    .value_high_o (value_high),
    .status_o     (status)
  );

  assign m_axis_tdata = {{PadW{1'b0}}, status, value_high, value_low};

endmodule

FILE: sim/b62_decode_checker.sv
// Checker for the base-62 decoder: watches both stream channels, predicts every result
// from the accepted characters and compares it with what the block returns.
// Depends on b62_pkg for widths, status codes and character constants.
`timescale 1ns / 100ps

module b62_decode_checker import b62_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] char_code
  input  logic                  s_axis_tlast,   // end_mark
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [63:0] value_low, [120:64] value_high,
                                                // [122:121] status, rest zero
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    n_ok_o,
  output int                    n_bad_digit_o,
  output int                    n_range_o
);

  localparam int MAX_DIGITS = MAX_DIGITS_DEF;

  typedef struct {
    logic [VAL_LOW_W-1:0]  lo;
    logic [VAL_HIGH_W-1:0] hi;
    b62_status_e           status;
  } decoded_t;

  decoded_t    decoded_q[$];
  logic [127:0] magnitude   = '0;
  logic [4:0]   digit_count = '0;
  logic         minus_seen  = 1'b0;
  logic         bad_seen    = 1'b0;
  int           results_seen = 0;

  initial begin
    mismatches_o  = 0;
    pending_o     = 0;
    n_ok_o        = 0;
    n_bad_digit_o = 0;
    n_range_o     = 0;
  end

  function automatic int digit_value(input logic [7:0] ch);
    if (ch >= CH_0 && ch <= CH_9) return int'(ch) - int'(CH_0);
    if (ch >= CH_UP_A && ch <= CH_UP_Z) return int'(ch) - int'(CH_UP_A) + int'(UP_BASE);
    if (ch >= CH_LO_A && ch <= CH_LO_Z) return int'(ch) - int'(CH_LO_A) + int'(LO_BASE);
    return -1;
  endfunction

  task automatic take_char(input logic [7:0] ch);
    int d;
    d = digit_value(ch);
    if (digit_count == 0 && !minus_seen && ch == CH_MINUS) begin
      minus_seen = 1'b1;
    end else begin
      // The count saturates one past the limit; characters beyond it are not examined.
      if (digit_count <= MAX_DIGITS) digit_count = digit_count + 5'd1;
      if (digit_count <= MAX_DIGITS) begin
        if (d < 0) begin
          bad_seen = 1'b1;
        end else if (!bad_seen) begin
          magnitude = magnitude * 128'd62 + 128'(d);
        end
      end
    end
  endtask

  task automatic close_text(output decoded_t res);
    logic [127:0] full;
    res.lo     = '0;
    res.hi     = '0;
    // Length is judged before digit validity.
    if ((digit_count == 0 && !minus_seen) || digit_count > MAX_DIGITS) begin
      res.status = ST_RANGE;
    end else if (bad_seen) begin
      res.status = ST_BAD_DIGIT;
    end else begin
      res.status = ST_OK;
      full       = minus_seen ? (~magnitude + 128'd1) : magnitude;
      res.lo     = full[63:0];
      res.hi     = full[120:64];
    end
    magnitude   = '0;
    digit_count = '0;
    minus_seen  = 1'b0;
    bad_seen    = 1'b0;
  endtask

  always @(posedge clk_i) begin
    decoded_t    want;
    logic [63:0] got_lo;
    logic [56:0] got_hi;
    logic [1:0]  got_st;
    logic [4:0]  got_pad;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tlast) begin
          close_text(want);
          decoded_q.push_back(want);
        end else begin
          take_char(s_axis_tdata);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_lo  = m_axis_tdata[63:0];
        got_hi  = m_axis_tdata[120:64];
        got_st  = m_axis_tdata[122:121];
        got_pad = m_axis_tdata[127:123];
        if (decoded_q.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: result %0d arrived with nothing outstanding: tdata %h",
                     $realtime, results_seen, m_axis_tdata);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = decoded_q.pop_front();
          if (got_lo !== want.lo || got_hi !== want.hi || got_st !== want.status ||
              got_pad !== 5'd0) begin
            if (mismatches_o < 10) begin
              $display("%0t: result %0d differs: value_low exp %h got %h",
                       $realtime, results_seen, want.lo, got_lo);
              $display("  value_high exp %h got %h, status exp %0d got %0d, pad %h",
                       want.hi, got_hi, want.status, got_st, got_pad);
            end
            mismatches_o <= mismatches_o + 1;
          end
          case (want.status)
            ST_OK:        n_ok_o        <= n_ok_o + 1;
            ST_BAD_DIGIT: n_bad_digit_o <= n_bad_digit_o + 1;
            default:      n_range_o     <= n_range_o + 1;
          endcase
        end
        results_seen++;
      end
      pending_o <= decoded_q.size();
    end
  end

endmodule

FILE: sim/tb_base62_text_to_int128.sv
// Top of the base-62 decoder testbench: clock, reset, character and result stimulus,
// and the verdict. Depends on b62_pkg, base62_text_to_int128 and b62_decode_checker.
`timescale 1ns / 100ps

module tb_base62_text_to_int128;
  import b62_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [7:0] char_code
  logic                  s_axis_tlast;   // end_mark
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [63:0] value_low, [120:64] value_high,
                                         // [122:121] status, rest zero
  int mismatches, pending, n_ok, n_bad_digit, n_range;
  int items_sent   = 0;
  int strings_sent = 0;
  int cycle_count  = 0;
  logic tx_burst   = 1'b0;
  logic [7:0] text_q[$];

  always #6 clk_i = ~clk_i;

  base62_text_to_int128 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  b62_decode_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .n_ok_o        (n_ok),
    .n_bad_digit_o (n_bad_digit),
    .n_range_o     (n_range)
  );

  function automatic logic [7:0] digit_char(input int v);
    if (v < int'(UP_BASE)) return CH_0 + 8'(v);
    if (v < int'(LO_BASE)) return CH_UP_A + 8'(v - int'(UP_BASE));
    return CH_LO_A + 8'(v - int'(LO_BASE));
  endfunction

  function automatic logic [7:0] non_digit_char();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(0, int'(CH_0) - 1));
      1:       return 8'($urandom_range(int'(CH_9) + 1, int'(CH_UP_A) - 1));
      2:       return 8'($urandom_range(int'(CH_UP_Z) + 1, int'(CH_LO_A) - 1));
      3:       return 8'($urandom_range(int'(CH_LO_Z) + 1, 255));
      default: return CH_MINUS;
    endcase
  endfunction

  task automatic push_item(input logic [7:0] ch, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Sends the characters held in text_q, then the end marker with a junk character.
  task automatic send_text();
    foreach (text_q[i]) push_item(text_q[i], 1'b0);
    push_item(8'($urandom_range(0, 255)), 1'b1);
    strings_sent++;
  endtask

  task automatic send_str(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic build_digits(input int len, input logic with_minus);
    text_q.delete();
    if (with_minus) text_q.push_back(CH_MINUS);
    repeat (len) text_q.push_back(digit_char($urandom_range(0, 61)));
  endtask

  initial begin : stimulus
    int pick, len, hits;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty text, lone minus, digit range edges, misplaced and doubled minus, non-digit bytes.
    send_str("");
    send_str("-");
    send_str("0");
    send_str("9Az");
    send_str("Za");
    send_str("-z");
    send_str("1-2");
    send_str("--");
    text_q.delete();
    text_q.push_back(8'hFF);
    text_q.push_back(8'h00);
    send_text();

    while (items_sent < RANDOM_ITEMS + 25) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      pick     = $urandom_range(0, 99);
      if (pick < 55) begin
        hits = $urandom_range(0, 9);
        len  = (hits < 2) ? MAX_DIGITS_DEF :
               (hits < 3) ? MAX_DIGITS_DEF - 1 : $urandom_range(1, MAX_DIGITS_DEF);
        build_digits(len, 1'($urandom_range(0, 1)));
      end else if (pick < 65) begin
        build_digits($urandom_range(MAX_DIGITS_DEF + 1, MAX_DIGITS_DEF + 6),
                     1'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) == 0)
          text_q[$urandom_range(0, text_q.size() - 1)] = non_digit_char();
      end else if (pick < 80) begin
        build_digits($urandom_range(1, MAX_DIGITS_DEF), 1'($urandom_range(0, 1)));
        hits = $urandom_range(1, 2);
        repeat (hits) text_q[$urandom_range(0, text_q.size() - 1)] = non_digit_char();
      end else if (pick < 87) begin
        build_digits(0, 1'($urandom_range(0, 1)));
      end else begin
        text_q.delete();
        len = $urandom_range(0, MAX_DIGITS_DEF + 2);
        repeat (len) text_q.push_back(8'($urandom_range(0, 255)));
      end
      send_text();
      // Let the block run dry at two points so that restart from idle is covered.
      if (strings_sent == 20 || strings_sent == 70) drain();
    end

    drain();
    repeat (10) @(negedge clk_i);
    $display("Sent %0d texts in %0d items; results ok %0d, invalid digit %0d,",
             strings_sent, items_sent, n_ok, n_bad_digit);
    $display("out of range %0d, with two long output holds and two full drains.", n_range);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : receiver
    int   gap;
    int   taken;
    logic rx_burst;
    m_axis_tready = 1'b0;
    taken         = 0;
    rx_burst      = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 15);
      // Hold off long enough for the block to fill and push back on its input.
      if (taken == 12 || taken == 45) gap = LONG_HOLD;
      if (gap != 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
